// ===== hdl/flash_save_memory_controller_assert.svh =====
// assertion macros shared by the flash save-memory controller rtl
`ifndef FLASH_SAVE_MEMORY_CONTROLLER_ASSERT_SVH
`define FLASH_SAVE_MEMORY_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FSMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define FSMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fsmc_pkg.sv =====
// shared types and constants of the flash save-memory controller
package fsmc_pkg;

  // store geometry; both sizes are powers of two
  localparam int SAVE_BYTES = 131072;
  localparam int PAGE_BYTES = 128;
  localparam int ADDR_W     = $clog2(SAVE_BYTES);
  localparam int PAGE_IDX_W = $clog2(PAGE_BYTES);
  localparam int PAGE_W     = ADDR_W - PAGE_IDX_W;
  localparam int STEP_W     = PAGE_IDX_W + 1;
  // doubled start offset plus byte index needs 18 bits
  localparam int RD_SUM_W   = (ADDR_W > 18) ? ADDR_W : 18;

  localparam logic [7:0]  ERASED_BYTE   = 8'hFF;
  localparam logic [31:0] CHIP_ID_RESET = 32'h00C2001E;

  // status words loaded by mode commands
  localparam logic [31:0] STATUS_STAT  = 32'h11118001;
  localparam logic [31:0] STATUS_READ  = 32'h11118004;
  localparam logic [31:0] STATUS_ERASE = 32'h11118008;

  // item kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // opcodes in the top byte of a command word
  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_COMMIT   = 8'hD2;
  localparam logic [7:0] OP_STATUS   = 8'hE1;
  localparam logic [7:0] OP_READ     = 8'hF0;
  localparam logic [7:0] OP_PAGE     = 8'h4B;
  localparam logic [7:0] OP_ERASE    = 8'h78;
  localparam logic [7:0] OP_WRITE    = 8'hB4;
  localparam logic [7:0] OP_PAGE_SET = 8'hA5;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_ERASE  = 3'd1,
    MODE_WRITE  = 3'd2,
    MODE_READ   = 3'd3,
    MODE_STATUS = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_READY,
    ST_READ_WAIT,
    ST_ERASE,
    ST_PROGRAM
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] cmd_word;
    logic [15:0] start_offset;
    logic [16:0] byte_index;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        accepted;
    logic        save_dirty;
    logic [2:0]  current_mode;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic                  en;
    logic [PAGE_IDX_W-1:0] addr;
    logic [7:0]            data;
  } buf_wr_t;

endpackage

// ===== hdl/flash_save_memory_controller.sv =====
// flash save-memory controller top level: command decode and page commit sequencer
//
//   channel  signals                          direction  carries
//   item     item_valid item_ready item       in         command, load or read
//   result   result_valid result_ready result out        one result per item
//   cfg      cfg_valid cfg_ready cfg_data     in         chip id word
//
// command words, byte loads and status reads push their result when accepted; a read in read mode
// waits in the read-wait state for the registered read port of the store memory
// a commit erase holds the item channel while it erases the page, a commit program while it
// programs it (page buffer read one step ahead of each store write)
// after reset the store is swept to 0xFF, one byte a cycle, with item_ready held low until the sweep ends
// results go through a two-entry queue; a stalled result channel holds items once it is full
module flash_save_memory_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  fsmc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output fsmc_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);

  `include "flash_save_memory_controller_assert.svh"

  fsmc_pkg::state_t                 state, state_next;
  fsmc_pkg::mode_t                  mode, mode_next;
  logic [fsmc_pkg::PAGE_W-1:0]      page, page_next;
  logic [31:0]                      status_word, status_next;
  logic [fsmc_pkg::STEP_W-1:0]      step, step_next;
  logic [fsmc_pkg::STEP_W-1:0]      step_prev;
  logic [31:0]                      chip_id;

  logic                             accept;
  logic                             st_ready;
  logic                             st_wait;
  logic                             q_full;
  logic                             q_push;
  fsmc_pkg::result_t                res;
  fsmc_pkg::store_wr_t              st_wr;
  logic                             st_rd_en;
  logic [fsmc_pkg::ADDR_W-1:0]      st_rd_addr;
  logic [7:0]                       st_rd_data;
  logic                             clear_busy;
  fsmc_pkg::buf_wr_t                buf_wr;
  logic [fsmc_pkg::PAGE_IDX_W-1:0]  buf_rd_addr;
  logic [7:0]                       buf_rd_data;
  logic [fsmc_pkg::RD_SUM_W-1:0]    rd_sum;

  assign st_ready   = (state == fsmc_pkg::ST_READY);
  assign st_wait    = (state == fsmc_pkg::ST_READ_WAIT);
  assign item_ready = st_ready && !clear_busy && !q_full;
  assign accept     = item_valid && item_ready;
  assign cfg_ready  = 1'b1;
  assign step_prev  = step - 1'b1;

  // read address, doubled start offset plus index, wrapped to the store
  assign rd_sum = fsmc_pkg::RD_SUM_W'({item.start_offset, 1'b0})
                + fsmc_pkg::RD_SUM_W'(item.byte_index);
  assign st_rd_addr = rd_sum[fsmc_pkg::ADDR_W-1:0];

  // chip id register
  always_ff @(posedge clk) begin
    if (rst) begin
      chip_id <= fsmc_pkg::CHIP_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      chip_id <= cfg_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fsmc_pkg::ST_READY;
      mode        <= fsmc_pkg::MODE_IDLE;
      page        <= '0;
      status_word <= '0;
      step        <= '0;
    end else begin
      state       <= state_next;
      mode        <= mode_next;
      page        <= page_next;
      status_word <= status_next;
      step        <= step_next;
    end
  end

  // decode and commit sequencing
  always_comb begin
    state_next  = state;
    mode_next   = mode;
    page_next   = page;
    status_next = status_word;
    step_next   = step;
    res         = '0;
    q_push      = 1'b0;
    st_rd_en    = 1'b0;
    st_wr       = '0;
    buf_wr      = '0;
    buf_rd_addr = step[fsmc_pkg::PAGE_IDX_W-1:0];

    unique case (state)
      fsmc_pkg::ST_READY: begin
        if (accept) begin
          unique case (item.command)
            fsmc_pkg::KIND_CMD: begin
              q_push       = 1'b1;
              res.accepted = 1'b1;
              unique case (item.cmd_word[31:24])
                fsmc_pkg::OP_COMMIT: begin
                  step_next = '0;
                  if (mode == fsmc_pkg::MODE_ERASE) begin
                    res.save_dirty = 1'b1;
                    state_next     = fsmc_pkg::ST_ERASE;
                  end else if (mode == fsmc_pkg::MODE_WRITE) begin
                    res.save_dirty = 1'b1;
                    state_next     = fsmc_pkg::ST_PROGRAM;
                  end
                  mode_next = fsmc_pkg::MODE_IDLE;
                end
                fsmc_pkg::OP_STATUS: begin
                  mode_next   = fsmc_pkg::MODE_STATUS;
                  status_next = fsmc_pkg::STATUS_STAT;
                end
                fsmc_pkg::OP_READ: begin
                  mode_next   = fsmc_pkg::MODE_READ;
                  status_next = fsmc_pkg::STATUS_READ;
                end
                fsmc_pkg::OP_PAGE: begin
                  // page index wraps to the page count
                  page_next = item.cmd_word[fsmc_pkg::PAGE_W-1:0];
                end
                fsmc_pkg::OP_ERASE: begin
                  mode_next   = fsmc_pkg::MODE_ERASE;
                  status_next = fsmc_pkg::STATUS_ERASE;
                end
                fsmc_pkg::OP_WRITE: begin
                  mode_next = fsmc_pkg::MODE_WRITE;
                end
                fsmc_pkg::OP_PAGE_SET: begin
                  page_next   = item.cmd_word[fsmc_pkg::PAGE_W-1:0];
                  status_next = fsmc_pkg::STATUS_READ;
                end
                fsmc_pkg::OP_NOP: begin
                  res.accepted = 1'b1;
                end
                default: begin
                  res.accepted = 1'b0;
                end
              endcase
            end
            fsmc_pkg::KIND_LOAD: begin
              q_push = 1'b1;
              if (mode == fsmc_pkg::MODE_WRITE) begin
                buf_wr.en    = 1'b1;
                buf_wr.addr  = item.byte_index[fsmc_pkg::PAGE_IDX_W-1:0];
                buf_wr.data  = item.data_byte;
                res.accepted = 1'b1;
              end
            end
            fsmc_pkg::KIND_READ: begin
              if (mode == fsmc_pkg::MODE_READ) begin
                // result follows once the store read returns
                st_rd_en   = 1'b1;
                state_next = fsmc_pkg::ST_READ_WAIT;
              end else begin
                q_push = 1'b1;
                if (mode == fsmc_pkg::MODE_STATUS) begin
                  res.accepted  = 1'b1;
                  res.read_data = item.byte_index[0] ? chip_id : status_word;
                end
              end
            end
            default: begin
              q_push = 1'b1;
            end
          endcase
        end
        res.current_mode = mode_next;
      end

      fsmc_pkg::ST_READ_WAIT: begin
        q_push           = 1'b1;
        res.read_data    = {24'h000000, st_rd_data};
        res.accepted     = 1'b1;
        res.current_mode = mode;
        state_next       = fsmc_pkg::ST_READY;
      end

      fsmc_pkg::ST_ERASE: begin
        st_wr.en   = 1'b1;
        st_wr.addr = {page, step[fsmc_pkg::PAGE_IDX_W-1:0]};
        st_wr.data = fsmc_pkg::ERASED_BYTE;
        step_next  = step + 1'b1;
        if (step == fsmc_pkg::STEP_W'(fsmc_pkg::PAGE_BYTES - 1)) begin
          state_next = fsmc_pkg::ST_READY;
        end
      end

      fsmc_pkg::ST_PROGRAM: begin
        // buffer byte read one step ahead of its store write
        st_wr.en   = (step != '0);
        st_wr.addr = {page, step_prev[fsmc_pkg::PAGE_IDX_W-1:0]};
        st_wr.data = buf_rd_data;
        step_next  = step + 1'b1;
        if (step == fsmc_pkg::STEP_W'(fsmc_pkg::PAGE_BYTES)) begin
          state_next = fsmc_pkg::ST_READY;
        end
      end

      default: begin
        state_next = fsmc_pkg::ST_READY;
      end
    endcase
  end

  fsmc_store u_store (
    .clk        (clk),
    .rst        (rst),
    .wr         (st_wr),
    .rd_en      (st_rd_en),
    .rd_addr    (st_rd_addr),
    .rd_data    (st_rd_data),
    .clear_busy (clear_busy)
  );

  fsmc_page_buf u_page_buf (
    .clk     (clk),
    .rst     (rst),
    .wr      (buf_wr),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  fsmc_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (res),
    .pop_ready (result_ready),
    .out_valid (result_valid),
    .out_data  (result),
    .full      (q_full)
  );

  // a result is never pushed into a full queue unless one leaves
  `FSMC_ASSERT_NOW(a_q_no_overflow, clk, rst, q_push, !q_full || result_ready, "queue overflow")
  // the sweep owns the store write port
  `FSMC_ASSERT_NOW(a_no_write_in_sweep, clk, rst, st_wr.en, !clear_busy, "store write during sweep")
  // the read-wait state, which delivers the byte of a read in read mode, is left on the next cycle
  `FSMC_ASSERT_NEXT(a_read_wait_once, clk, rst, st_wait, st_ready, "read wait not left")
  // a commit that dirties a page leaves the item channel busy
  `FSMC_ASSERT_NEXT(a_commit_busy, clk, rst, res.save_dirty, !item_ready, "item taken in commit")

endmodule

// ===== hdl/fsmc_page_buf.sv =====
// 128-byte page buffer with per-entry valid bits, registered read
module fsmc_page_buf (
  input  logic                           clk,
  input  logic                           rst,
  input  fsmc_pkg::buf_wr_t              wr,
  input  logic [fsmc_pkg::PAGE_IDX_W-1:0] rd_addr,
  output logic [7:0]                     rd_data
);

  logic [7:0]                      mem [fsmc_pkg::PAGE_BYTES];
  logic [fsmc_pkg::PAGE_BYTES-1:0] valid;
  logic [7:0]                      mem_q;
  logic                            valid_q;

  // byte storage
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q <= mem[rd_addr];
  end

  // valid bits, cleared at reset so unwritten entries read zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  assign rd_data = valid_q ? mem_q : 8'h00;

endmodule

// ===== hdl/fsmc_store.sv =====
// save store memory with post-reset erase sweep
module fsmc_store (
  input  logic                        clk,
  input  logic                        rst,
  input  fsmc_pkg::store_wr_t         wr,
  input  logic                        rd_en,
  input  logic [fsmc_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                  rd_data,
  output logic                        clear_busy
);

  logic [7:0]                  mem [fsmc_pkg::SAVE_BYTES];
  logic [fsmc_pkg::ADDR_W-1:0] clr_addr;

  // sweep counter, one byte per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_addr   <= '0;
    end else if (clear_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == fsmc_pkg::ADDR_W'(fsmc_pkg::SAVE_BYTES - 1)) begin
        clear_busy <= 1'b0;
      end
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (clear_busy) begin
      mem[clr_addr] <= fsmc_pkg::ERASED_BYTE;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/fsmc_out_q.sv =====
// two-entry result queue between the controller and the result channel
module fsmc_out_q (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fsmc_pkg::result_t push_data,
  input  logic              pop_ready,
  output logic              out_valid,
  output fsmc_pkg::result_t out_data,
  output logic              full
);

  fsmc_pkg::result_t slot0;
  fsmc_pkg::result_t slot1;
  logic [1:0]        count;
  logic              pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = slot0;
  assign pop       = out_valid && pop_ready;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // entry shifting
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        slot0 <= push_data;
      end else begin
        slot0 <= slot1;
      end
      if (push && count == 2'd2) begin
        slot1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule
